/* hw/rtl/mcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcb_pkg
// shared types, codes and the cell combine function for the masked cell
// blitter
// ----------------------------------------------------------------------------
package mcb_pkg;

    localparam int FRAME_CELLS_DEFAULT = 2048;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int ROW_BASE_W  = 17;
    localparam int COL_W       = 8;
    localparam int IDX_W       = 18;
    localparam int FRAME_IDX_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLIT_MODE    = 3'd4;

    localparam logic [1:0] MODE_PUT = 2'd0;
    localparam logic [1:0] MODE_AND = 2'd1;
    localparam logic [1:0] MODE_OR  = 2'd2;
    localparam logic [1:0] MODE_GET = 2'd3;

    localparam logic [8:0] FRAME_WIDTH_RESET  = 9'd64;
    localparam logic [8:0] SPRITE_WIDTH_RESET = 9'd8;
    localparam logic [8:0] SPRITE_WIDTH_MAX   = 9'd256;
    localparam logic [7:0] MASK_CLEAR         = 8'h00;

    typedef struct packed {
        logic [7:0] color;
        logic [7:0] chr;
        logic [7:0] mask;
    } cell_t;

    typedef struct packed {
        logic [8:0]            frame_width;
        logic [8:0]            sprite_width;
        logic [ROW_BASE_W-1:0] origin_base;
        logic [1:0]            blit_mode;
    } cfg_t;

    function automatic cell_t blend_cell(input cell_t frame, input cell_t sprite,
                                         input logic [1:0] mode);
        cell_t res;
        res = frame;
        unique case (mode)
            MODE_PUT: res = sprite;
            MODE_AND: res.mask = frame.mask & sprite.mask;
            MODE_OR:
            begin
                res.mask = frame.mask | sprite.mask;
                if (res.mask == MASK_CLEAR)
                begin
                    res.color = sprite.color;
                    res.chr   = sprite.chr;
                end
            end
            default: res = frame;
        endcase
        return res;
    endfunction

endpackage

/* hw/rtl/mcb_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcb_cfg_regs
// configuration registers; keeps the origin base address up to date on
// every write and clamps the sprite width
// ----------------------------------------------------------------------------
module mcb_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [mcb_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [mcb_pkg::CFG_DATA_W-1:0]     wr_data,
    output mcb_pkg::cfg_t                      cfg
);
    import mcb_pkg::*;

    logic [8:0]            frame_width_reg,  frame_width_next;
    logic [8:0]            sprite_width_reg, sprite_width_next;
    logic [7:0]            origin_x_reg,     origin_x_next;
    logic [7:0]            origin_y_reg,     origin_y_next;
    logic [1:0]            blit_mode_reg,    blit_mode_next;
    logic [ROW_BASE_W-1:0] origin_base_reg,  origin_base_next;
    logic [8:0]            sprite_eff;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        sprite_width_next = sprite_width_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        blit_mode_next    = blit_mode_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_FRAME_WIDTH:  frame_width_next  = wr_data;
                REG_SPRITE_WIDTH: sprite_width_next = wr_data;
                REG_ORIGIN_X:     origin_x_next     = wr_data[7:0];
                REG_ORIGIN_Y:     origin_y_next     = wr_data[7:0];
                REG_BLIT_MODE:    blit_mode_next    = wr_data[1:0];
                default:          frame_width_next  = frame_width_reg;
            endcase
        end
        origin_base_next = ROW_BASE_W'(origin_y_next) * ROW_BASE_W'(frame_width_next)
                         + ROW_BASE_W'(origin_x_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            sprite_width_reg <= SPRITE_WIDTH_RESET;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            blit_mode_reg    <= MODE_PUT;
            origin_base_reg  <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            sprite_width_reg <= sprite_width_next;
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            blit_mode_reg    <= blit_mode_next;
            origin_base_reg  <= origin_base_next;
        end
    end

    // zero acts as one, anything above the max acts as the max
    always_comb
    begin
        if (sprite_width_reg == '0)
            sprite_eff = 9'd1;
        else if (sprite_width_reg > SPRITE_WIDTH_MAX)
            sprite_eff = SPRITE_WIDTH_MAX;
        else
            sprite_eff = sprite_width_reg;
    end

    assign cfg.frame_width  = frame_width_reg;
    assign cfg.sprite_width = sprite_eff;
    assign cfg.origin_base  = origin_base_reg;
    assign cfg.blit_mode    = blit_mode_reg;

endmodule

/* hw/rtl/mcb_frame_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcb_frame_store
// frame cell memory, one write and one registered read port, with a
// clearing sweep after reset
// ----------------------------------------------------------------------------
module mcb_frame_store #(
    parameter int FRAME_CELLS = mcb_pkg::FRAME_CELLS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [$clog2(FRAME_CELLS)-1:0]  rd_addr,
    output mcb_pkg::cell_t                  rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(FRAME_CELLS)-1:0]  wr_addr,
    input  mcb_pkg::cell_t                  wr_data,
    output logic                            clearing
);
    import mcb_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_CELLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_CELLS - 1);

    cell_t             mem [FRAME_CELLS];
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    cell_t             mem_wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
                clr_active_reg <= 1'b0;
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    assign clearing = clr_active_reg;

endmodule

/* hw/rtl/masked_cell_blitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_cell_blitter
// character cell frame store with a rectangle walk and put, and mask,
// or image and get read-modify-write per sprite cell
//
//   channel  handshake              payload
//   in       in_valid / in_stall    first_cell, cell_color, cell_char, cell_mask
//   out      out_valid / out_stall  frame_index, result_color, result_char,
//                                   result_mask, out_of_range
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// per cell the beat is taken and the store read, then the cell is combined,
// written back (not in get mode or out of range), loaded into the output register
// after reset the store is swept to zero; in_stall
// stays high during the sweep, cfg writes are taken at once
// the next input beat is taken while a result waits; a result that cannot
// be loaded because out is stalled holds the block in its write-back cycle
// ----------------------------------------------------------------------------
module masked_cell_blitter #(
    parameter int FRAME_CELLS = mcb_pkg::FRAME_CELLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 first_cell,
    input  logic [7:0]                           cell_color,
    input  logic [7:0]                           cell_char,
    input  logic [7:0]                           cell_mask,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mcb_pkg::FRAME_IDX_W-1:0]      frame_index,
    output logic [7:0]                           result_color,
    output logic [7:0]                           result_char,
    output logic [7:0]                           result_mask,
    output logic                                 out_of_range,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mcb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mcb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mcb_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_CELLS);
    localparam logic [IDX_W-1:0] FRAME_LIMIT = IDX_W'(FRAME_CELLS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RMW  = 1'b1;

    cfg_t                   cfg;
    logic                   clearing;
    logic                   state_reg,     state_next;
    logic [ROW_BASE_W-1:0]  row_base_reg,  row_base_next;
    logic [COL_W-1:0]       col_reg,       col_next;
    logic [FRAME_IDX_W-1:0] idx_reg;
    logic                   oor_reg;
    cell_t                  sprite_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [FRAME_IDX_W-1:0] out_index_reg;
    cell_t                  out_cell_reg;
    logic                   out_oor_reg;

    logic                   in_accept;
    logic [ROW_BASE_W-1:0]  base_sel;
    logic [COL_W-1:0]       col_sel;
    logic [IDX_W-1:0]       idx_full;
    logic                   idx_oor;
    logic [COL_W:0]         col_inc;
    logic                   can_finish;
    logic                   st_rd_en;
    logic                   st_wr_en;
    cell_t                  st_rd_data;
    cell_t                  blended;
    cell_t                  sprite_in;

    mcb_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mcb_frame_store #(
        .FRAME_CELLS (FRAME_CELLS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (st_rd_en),
        .rd_addr  (idx_full[ADDR_W-1:0]),
        .rd_data  (st_rd_data),
        .wr_en    (st_wr_en),
        .wr_addr  (idx_reg[ADDR_W-1:0]),
        .wr_data  (blended),
        .clearing (clearing)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || clearing;
    assign in_accept = in_valid && !in_stall;

    // address walk
    assign base_sel = first_cell ? cfg.origin_base : row_base_reg;
    assign col_sel  = first_cell ? '0 : col_reg;
    assign idx_full = IDX_W'(base_sel) + IDX_W'(col_sel);
    assign idx_oor  = idx_full >= FRAME_LIMIT;
    assign col_inc  = {1'b0, col_sel} + 1'b1;

    always_comb
    begin
        row_base_next = row_base_reg;
        col_next      = col_reg;
        if (in_accept)
        begin
            if (col_inc >= cfg.sprite_width)
            begin
                col_next      = '0;
                row_base_next = base_sel + ROW_BASE_W'(cfg.frame_width);
            end
            else
            begin
                row_base_next = base_sel;
                col_next      = col_inc[COL_W-1:0];
            end
        end
    end

    assign sprite_in.color = cell_color;
    assign sprite_in.chr   = cell_char;
    assign sprite_in.mask  = cell_mask;

    assign st_rd_en   = in_accept && !idx_oor;
    assign can_finish = !out_valid_reg || !out_stall;
    assign blended    = blend_cell(st_rd_data, sprite_reg, cfg.blit_mode);
    assign st_wr_en   = (state_reg == ST_RMW) && can_finish && !oor_reg
                        && (cfg.blit_mode != MODE_GET);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_RMW;
            end
            ST_RMW:
            begin
                if (can_finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_base_reg  <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_base_reg  <= row_base_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            idx_reg    <= idx_full[FRAME_IDX_W-1:0];
            oor_reg    <= idx_oor;
            sprite_reg <= sprite_in;
        end
        if ((state_reg == ST_RMW) && can_finish)
        begin
            out_index_reg <= idx_reg;
            out_oor_reg   <= oor_reg;
            out_cell_reg  <= oor_reg ? cell_t'('0) : blended;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_index  = out_index_reg;
    assign result_color = out_cell_reg.color;
    assign result_char  = out_cell_reg.chr;
    assign result_mask  = out_cell_reg.mask;
    assign out_of_range = out_oor_reg;

    a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> !oor_reg)
        else $error("store written for an out of range cell");

    a_get_never_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW && cfg.blit_mode == MODE_GET) |-> !st_wr_en)
        else $error("store written in get mode");

    a_accept_to_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RMW))
        else $error("accepted beat did not reach write-back");

    a_result_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RMW))
        else $error("result shown without a write-back cycle");

endmodule
